@@ rtl/tspi_pkg.sv @@
`default_nettype none
package tspi_pkg;

   // Field widths of one beat.
   localparam int ACTION_W = 2;
   localparam int COORD_W  = 16;
   localparam int TIME_W   = 32;
   localparam int ENTRY_W  = TIME_W + 2 * COORD_W;
   localparam int DELAY_W  = 16;

   // Defaults for the top-level parameters.
   localparam int BUFFER_DEPTH_DEF = 16;
   localparam int WRAP_SIZE_DEF    = 256;

   // Action codes carried on the request channel.
   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH     = 2'd0,
      ACT_QUERY    = 2'd1,
      ACT_OVERRIDE = 2'd2,
      ACT_UNDEF    = 2'd3
   } action_type;

   // Configuration register indexes.
   typedef enum logic {
      CSR_LERP_ENABLED = 1'b0,
      CSR_LERP_DELAY   = 1'b1
   } csr_index_type;

   // One classified request as it sits in the decoupling queue.
   typedef struct packed {
      action_type               act;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [TIME_W-1:0]  t;
   } item_type;

   // Head of the queue as seen by the execution side.
   typedef struct packed {
      logic     valid;
      item_type item;
   } qhead_type;

endpackage
`default_nettype wire

@@ rtl/tspi_req_if.sv @@
`default_nettype none
interface tspi_req_if;
   import tspi_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [ACTION_W-1:0]       action;
   logic signed [COORD_W-1:0] x_value;
   logic signed [COORD_W-1:0] y_value;
   logic signed [TIME_W-1:0]  time_value;

   modport source (output valid, action, x_value, y_value, time_value, input ready);
   modport sink (input valid, action, x_value, y_value, time_value, output ready);
endinterface
`default_nettype wire

@@ rtl/tspi_rsp_if.sv @@
`default_nettype none
interface tspi_rsp_if;
   import tspi_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] pos_x;
   logic signed [COORD_W-1:0] pos_y;
   logic                      status;

   modport source (output valid, pos_x, pos_y, status, input ready);
   modport sink (input valid, pos_x, pos_y, status, output ready);
endinterface
`default_nettype wire

@@ rtl/tspi_ram.sv @@
`default_nettype none
module tspi_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

@@ rtl/tspi_front.sv @@
`default_nettype none
module tspi_front (
   input  wire logic             clock,
   input  wire logic             reset,
   tspi_req_if.sink              req_chan,
   input  wire logic             pop,
   output tspi_pkg::qhead_type   head
);
   import tspi_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;
   logic       do_pop;
   item_type   incoming;

   // Classify the incoming beat into a queue entry.
   always_comb begin
      incoming.act = action_type'(req_chan.action);
      incoming.x   = req_chan.x_value;
      incoming.y   = req_chan.y_value;
      incoming.t   = req_chan.time_value;
   end

   assign req_chan.ready = (fill_ff != 2'd2);
   assign push           = req_chan.valid && req_chan.ready;
   assign do_pop         = pop && (fill_ff != 2'd0);

   assign head.valid = (fill_ff != 2'd0);
   assign head.item  = slot_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping of the two-entry queue.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= incoming;
      end
   end
endmodule
`default_nettype wire

@@ rtl/tspi_back.sv @@
`default_nettype none
module tspi_back #(
   parameter int BUFFER_DEPTH = tspi_pkg::BUFFER_DEPTH_DEF,
   parameter int WRAP_SIZE    = tspi_pkg::WRAP_SIZE_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire tspi_pkg::qhead_type         head,
   output logic                             pop,
   input  wire logic                        lerp_enabled,
   input  wire logic [tspi_pkg::DELAY_W-1:0] lerp_delay,
   output logic                             ram_wr_en,
   output logic [(BUFFER_DEPTH > 1 ? $clog2(BUFFER_DEPTH) : 1)-1:0] ram_wr_addr,
   output logic [tspi_pkg::ENTRY_W-1:0]     ram_wr_data,
   output logic [(BUFFER_DEPTH > 1 ? $clog2(BUFFER_DEPTH) : 1)-1:0] ram_rd_addr,
   input  wire logic [tspi_pkg::ENTRY_W-1:0] ram_rd_data,
   tspi_rsp_if.source                       rsp_chan
);
   import tspi_pkg::*;

   localparam int IW  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int CW  = $clog2(BUFFER_DEPTH + 1);
   localparam int WW  = $clog2(WRAP_SIZE);
   localparam int NW  = WW + 36;
   localparam int DCW = $clog2(NW + 1);
   localparam int TW  = TIME_W + 1;
   localparam int SW  = TIME_W + 2;
   localparam logic [31:0] WRAP_RECIP = 32'(64'h1_0000_0000 / WRAP_SIZE);
   localparam logic [WW:0] WRAP_OFS = (WW + 1)'(32768 % WRAP_SIZE);
   localparam logic [WW:0] WRAP_ADD = (WW + 1)'(WRAP_SIZE - 32768 % WRAP_SIZE);
   localparam logic [NW-1:0] SAT_POS = NW'(32767);
   localparam logic [NW-1:0] SAT_NEG = NW'(32768);

   typedef enum logic [12:0] {
      S_IDLE = 13'b0_0000_0000_0001,
      S_SNAP = 13'b0_0000_0000_0010,
      S_RD1  = 13'b0_0000_0000_0100,
      S_RDE0 = 13'b0_0000_0000_1000,
      S_RDE1 = 13'b0_0000_0001_0000,
      S_WRAP = 13'b0_0000_0010_0000,
      S_REM  = 13'b0_0000_0100_0000,
      S_FIX  = 13'b0_0000_1000_0000,
      S_MUL  = 13'b0_0001_0000_0000,
      S_SUM  = 13'b0_0010_0000_0000,
      S_DIV  = 13'b0_0100_0000_0000,
      S_FIN  = 13'b0_1000_0000_0000,
      S_OUT  = 13'b1_0000_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [IW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic signed [COORD_W-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic status_ff, status_in;
   logic signed [TW-1:0] t_ff, t_in;
   logic [ENTRY_W-1:0] e0_ff, e0_in;
   logic [TIME_W-1:0]  t1_ff, t1_in;

   // Coordinate order in the four-lane arrays: x0, x1, y0, y1.
   logic [WW-1:0]      rem_w_ff [4];
   logic [WW-1:0]      rem_w_in [4];
   logic [COORD_W-1:0] src_ff [4];
   logic [COORD_W-1:0] src_in [4];
   logic [COORD_W-1:0] wq_ff [4];
   logic [COORD_W-1:0] wq_in [4];
   logic [WW-1:0]      w_ff [4];
   logic [WW-1:0]      w_in [4];
   logic [DCW-1:0]     cnt_ff, cnt_in;

   logic signed [TW-1:0] dur_ff, dur_in;
   logic signed [SW-1:0] since_ff, since_in;
   logic                 hold_ff, hold_in;
   logic signed [WW+TW:0]   pa_ff [2];
   logic signed [WW+TW:0]   pa_in [2];
   logic signed [WW+SW:0]   pb_ff [2];
   logic signed [WW+SW:0]   pb_in [2];
   logic [TW-1:0]           dmag_ff, dmag_in;
   logic [SW-1:0]           drem_ff [2];
   logic [SW-1:0]           drem_in [2];
   logic [NW-1:0]           quo_ff [2];
   logic [NW-1:0]           quo_in [2];
   logic                    neg_ff [2];
   logic                    neg_in [2];

   logic rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_W-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic rsp_status_ff, rsp_status_in;

   function automatic logic [IW-1:0] ptr_add(input logic [IW-1:0] p, input logic [CW-1:0] k);
      logic [CW:0] s;
      s = (CW + 1)'(p) + (CW + 1)'(k);
      if (s >= (CW + 1)'(BUFFER_DEPTH)) begin
         s = s - (CW + 1)'(BUFFER_DEPTH);
      end
      return s[IW-1:0];
   endfunction

   function automatic logic signed [COORD_W-1:0] sat_mag(input logic [NW-1:0] q, input logic neg);
      logic signed [COORD_W-1:0] r;
      if (!neg) begin
         r = (q > SAT_POS) ? COORD_W'(32767) : $signed(q[COORD_W-1:0]);
      end else begin
         r = (q > SAT_NEG) ? $signed(COORD_W'(32768)) : $signed(-q[COORD_W-1:0]);
      end
      return r;
   endfunction

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.pos_x  = rsp_x_ff;
   assign rsp_chan.pos_y  = rsp_y_ff;
   assign rsp_chan.status = rsp_status_ff;

   // Execution sequencer: one request at a time, then the result register.
   always_comb begin
      logic [WW:0]        r2;
      logic signed [NW-1:0] nsum;
      logic [NW-1:0]      nmag;
      logic [SW-1:0]      q2;
      logic               ge;
      logic               past;
      logic signed [WW:0] diff;
      logic [IW-1:0]      nh;
      logic [47:0]        prod;
      logic [31:0]        mw;
      logic [COORD_W-1:0] rr;

      state_in   = state_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      status_in  = status_ff;
      t_in       = t_ff;
      e0_in      = e0_ff;
      t1_in      = t1_ff;
      rem_w_in   = rem_w_ff;
      src_in     = src_ff;
      wq_in      = wq_ff;
      w_in       = w_ff;
      cnt_in     = cnt_ff;
      dur_in     = dur_ff;
      since_in   = since_ff;
      hold_in    = hold_ff;
      pa_in      = pa_ff;
      pb_in      = pb_ff;
      dmag_in    = dmag_ff;
      drem_in    = drem_ff;
      quo_in     = quo_ff;
      neg_in     = neg_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_status_in = rsp_status_ff;
      pop         = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = ptr_add(head_ff, count_ff);
      ram_wr_data = {head.item.t, head.item.y, head.item.x};
      ram_rd_addr = head_ff;
      r2   = '0;
      nsum = '0;
      nmag = '0;
      q2   = '0;
      ge   = 1'b0;
      past = 1'b0;
      diff = '0;
      nh   = head_ff;
      prod = '0;
      mw   = '0;
      rr   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               pop       = 1'b1;
               status_in = 1'b0;
               t_in      = TW'(head.item.t) - TW'($signed({1'b0, lerp_delay}));
               state_in  = S_OUT;
               unique case (head.item.act)
                  ACT_PUSH: begin
                     if (count_ff == CW'(BUFFER_DEPTH)) begin
                        status_in = 1'b1;
                     end else begin
                        ram_wr_en = 1'b1;
                        count_in  = count_ff + CW'(1);
                     end
                  end
                  ACT_QUERY: begin
                     if (!lerp_enabled) begin
                        if (count_ff != '0) begin
                           nh          = ptr_add(head_ff, count_ff - CW'(1));
                           head_in     = nh;
                           count_in    = CW'(1);
                           ram_rd_addr = nh;
                           state_in    = S_SNAP;
                        end
                     end else if (count_ff >= CW'(2)) begin
                        ram_rd_addr = ptr_add(head_ff, CW'(1));
                        state_in    = S_RD1;
                     end
                  end
                  ACT_OVERRIDE: begin
                     cur_x_in = head.item.x;
                     cur_y_in = head.item.y;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SNAP: begin
            cur_x_in = ram_rd_data[COORD_W-1:0];
            cur_y_in = ram_rd_data[2*COORD_W-1:COORD_W];
            state_in = S_OUT;
         end
         S_RD1: begin
            // Drop the oldest sample once the second one is already behind.
            if (TW'($signed(ram_rd_data[ENTRY_W-1:2*COORD_W])) < t_ff) begin
               nh       = ptr_add(head_ff, CW'(1));
               head_in  = nh;
               count_in = count_ff - CW'(1);
               state_in = (count_ff >= CW'(3)) ? S_RDE0 : S_OUT;
            end else begin
               state_in = S_RDE0;
            end
            ram_rd_addr = nh;
         end
         S_RDE0: begin
            e0_in       = ram_rd_data;
            ram_rd_addr = ptr_add(head_ff, CW'(1));
            state_in    = S_RDE1;
         end
         S_RDE1: begin
            t1_in     = ram_rd_data[ENTRY_W-1:2*COORD_W];
            src_in[0] = {~e0_ff[COORD_W-1], e0_ff[COORD_W-2:0]};
            src_in[1] = {~ram_rd_data[COORD_W-1], ram_rd_data[COORD_W-2:0]};
            src_in[2] = {~e0_ff[2*COORD_W-1], e0_ff[2*COORD_W-2:COORD_W]};
            src_in[3] = {~ram_rd_data[2*COORD_W-1], ram_rd_data[2*COORD_W-2:COORD_W]};
            state_in = S_WRAP;
         end
         S_WRAP: begin
            // Quotient of the offset coordinate by the wrap size through a
            // reciprocal multiply; the estimate is at most one too low.
            for (int i = 0; i < 4; i++) begin
               prod     = 48'(src_ff[i]) * 48'(WRAP_RECIP);
               wq_in[i] = prod[47:32];
            end
            state_in = S_REM;
         end
         S_REM: begin
            // Remainder from the estimate, then one correcting subtract.
            for (int i = 0; i < 4; i++) begin
               mw = 32'(wq_ff[i]) * 32'(WRAP_SIZE);
               rr = src_ff[i] - mw[COORD_W-1:0];
               if (rr >= COORD_W'(WRAP_SIZE)) begin
                  rr = rr - COORD_W'(WRAP_SIZE);
               end
               rem_w_in[i] = rr[WW-1:0];
            end
            state_in = S_FIX;
         end
         S_FIX: begin
            // Remove the offset that made the coordinate unsigned.
            for (int i = 0; i < 4; i++) begin
               r2 = {1'b0, rem_w_ff[i]};
               r2 = (r2 >= WRAP_OFS) ? r2 - WRAP_OFS : r2 + WRAP_ADD;
               w_in[i] = r2[WW-1:0];
            end
            dur_in   = TW'($signed(t1_ff)) - TW'($signed(e0_ff[ENTRY_W-1:2*COORD_W]));
            since_in = SW'(t_ff) - SW'($signed(e0_ff[ENTRY_W-1:2*COORD_W]));
            state_in = S_MUL;
         end
         S_MUL: begin
            for (int i = 0; i < 2; i++) begin
               diff     = $signed({1'b0, w_ff[2*i+1]}) - $signed({1'b0, w_ff[2*i]});
               pa_in[i] = $signed({1'b0, w_ff[2*i]}) * dur_ff;
               pb_in[i] = diff * since_ff;
            end
            past    = (dur_ff > 0) ? (since_ff > SW'(dur_ff)) : (since_ff < SW'(dur_ff));
            hold_in = (dur_ff == '0) || past;
            state_in = S_SUM;
         end
         S_SUM: begin
            if (hold_ff) begin
               cur_x_in = COORD_W'(w_ff[1]);
               cur_y_in = COORD_W'(w_ff[3]);
               state_in = S_OUT;
            end else begin
               for (int i = 0; i < 2; i++) begin
                  nsum       = NW'(pa_ff[i]) + NW'(pb_ff[i]);
                  nmag       = nsum[NW-1] ? NW'(-nsum) : NW'(nsum);
                  quo_in[i]  = nmag;
                  drem_in[i] = '0;
                  neg_in[i]  = nsum[NW-1] ^ dur_ff[TW-1];
               end
               dmag_in  = dur_ff[TW-1] ? TW'(-dur_ff) : TW'(dur_ff);
               cnt_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // Restoring division, one quotient bit per cycle in both lanes.
            for (int i = 0; i < 2; i++) begin
               q2 = {drem_ff[i][SW-2:0], quo_ff[i][NW-1]};
               ge = (q2 >= SW'(dmag_ff));
               drem_in[i] = ge ? q2 - SW'(dmag_ff) : q2;
               quo_in[i]  = {quo_ff[i][NW-2:0], ge};
            end
            cnt_in = cnt_ff + DCW'(1);
            if (cnt_ff == DCW'(NW - 1)) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            cur_x_in = sat_mag(quo_ff[0], neg_ff[0]);
            cur_y_in = sat_mag(quo_ff[1], neg_ff[1]);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_x_in      = cur_x_ff;
               rsp_y_in      = cur_y_ff;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      t_ff          <= t_in;
      e0_ff         <= e0_in;
      t1_ff         <= t1_in;
      rem_w_ff      <= rem_w_in;
      src_ff        <= src_in;
      wq_ff         <= wq_in;
      w_ff          <= w_in;
      cnt_ff        <= cnt_in;
      dur_ff        <= dur_in;
      since_ff      <= since_in;
      hold_ff       <= hold_in;
      pa_ff         <= pa_in;
      pb_ff         <= pb_in;
      dmag_ff       <= dmag_in;
      drem_ff       <= drem_in;
      quo_ff        <= quo_in;
      neg_ff        <= neg_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_status_ff <= rsp_status_in;
   end
endmodule
`default_nettype wire

@@ rtl/timestamped_position_interpolator_core.sv @@
`default_nettype none
// Keeps a FIFO of timestamped 2-D samples and a current position, and answers
// each request beat with exactly one response beat carrying the position after
// that request and a drop flag. A front queue of two beats takes requests while
// the execution sequencer is busy, so the requester stalls only when both slots
// are full. An interpolating query reduces each coordinate by the wrap size with
// a reciprocal multiply and one correcting subtract, and the shared restoring
// divider produces one quotient bit per cycle for both axes at once. A stalled
// response beat holds the sequencer for as long as it waits. Samples live in a
// single-port-write, registered-read RAM of BUFFER_DEPTH entries; entries are
// only read inside the FIFO's fill, so the RAM needs no clearing pass after reset.
module timestamped_position_interpolator_core #(
   parameter int BUFFER_DEPTH = tspi_pkg::BUFFER_DEPTH_DEF,
   parameter int WRAP_SIZE    = tspi_pkg::WRAP_SIZE_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   tspi_req_if.sink                          req_chan,
   tspi_rsp_if.source                        rsp_chan,
   input  wire logic                         csr_write_enable,
   input  wire logic                         csr_index,
   input  wire logic [tspi_pkg::DELAY_W-1:0] csr_write_data
);
   import tspi_pkg::*;

   localparam int IW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

   qhead_type          head;
   logic               pop;
   logic               lerp_enabled_ff, lerp_enabled_in;
   logic [DELAY_W-1:0] lerp_delay_ff, lerp_delay_in;
   logic               ram_wr_en;
   logic [IW-1:0]      ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic [IW-1:0]      ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;

   // Configuration registers.
   always_comb begin
      lerp_enabled_in = lerp_enabled_ff;
      lerp_delay_in   = lerp_delay_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_LERP_ENABLED: lerp_enabled_in = csr_write_data[0];
            CSR_LERP_DELAY:   lerp_delay_in   = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lerp_enabled_ff <= 1'b0;
         lerp_delay_ff   <= '0;
      end else begin
         lerp_enabled_ff <= lerp_enabled_in;
         lerp_delay_ff   <= lerp_delay_in;
      end
   end

   tspi_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .pop      (pop),
      .head     (head)
   );

   tspi_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (BUFFER_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   tspi_back #(
      .BUFFER_DEPTH (BUFFER_DEPTH),
      .WRAP_SIZE    (WRAP_SIZE)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .pop          (pop),
      .lerp_enabled (lerp_enabled_ff),
      .lerp_delay   (lerp_delay_ff),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_data  (ram_rd_data),
      .rsp_chan     (rsp_chan)
   );
endmodule
`default_nettype wire

@@ dv/timestamped_position_interpolator_core_test.sv @@
module timestamped_position_interpolator_core_test;
   import tspi_pkg::*;

   localparam int DEPTH      = 16;
   localparam int WRAP       = 256;
   localparam int CYCLE_CAP  = 1000000;

   // Expected response of one beat.
   typedef struct {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic                      status;
   } position_type;

   // Tracks the interpolator state and checks response beats in order.
   class position_scoreboard;
      logic [ENTRY_W-1:0] store [DEPTH];
      int unsigned head;
      int unsigned fill;
      longint cur_x, cur_y;
      bit lerp_on;
      longint delay;
      position_type pending [$];
      int errors;

      function new();
         head = 0; fill = 0; cur_x = 0; cur_y = 0;
         lerp_on = 0; delay = 0; errors = 0;
      endfunction

      function longint sat16(longint v);
         if (v > 32767) return 32767;
         if (v < -32768) return -32768;
         return v;
      endfunction

      function longint wrap_coord(longint v);
         return ((v % WRAP) + WRAP) % WRAP;
      endfunction

      function logic [ENTRY_W-1:0] entry(int unsigned k);
         return store[(head + k) % DEPTH];
      endfunction

      function longint blend(longint a, longint b, longint dur, longint since);
         longint w0, w1;
         bit past;
         w0 = wrap_coord(a);
         w1 = wrap_coord(b);
         if (dur == 0) return w1;
         past = (dur > 0) ? (since > dur) : (since < dur);
         if (past) return w1;
         return (w0 * dur + (w1 - w0) * since) / dur;
      endfunction

      function void run_query(longint tq);
         logic [ENTRY_W-1:0] e0, e1;
         longint t, t0, t1;
         if (!lerp_on) begin
            if (fill > 0) begin
               head = (head + fill - 1) % DEPTH;
               fill = 1;
               e0 = entry(0);
               cur_x = longint'($signed(e0[15:0]));
               cur_y = longint'($signed(e0[31:16]));
            end
            return;
         end
         t = tq - delay;
         if (fill >= 2) begin
            e1 = entry(1);
            if (longint'($signed(e1[63:32])) < t) begin
               head = (head + 1) % DEPTH;
               fill--;
            end
         end
         if (fill >= 2) begin
            e0 = entry(0);
            e1 = entry(1);
            t0 = longint'($signed(e0[63:32]));
            t1 = longint'($signed(e1[63:32]));
            cur_x = sat16(blend($signed(e0[15:0]), $signed(e1[15:0]), t1 - t0, t - t0));
            cur_y = sat16(blend($signed(e0[31:16]), $signed(e1[31:16]), t1 - t0, t - t0));
         end
      endfunction

      // Notes an accepted request beat and queues its expected response.
      function void note_request(logic [ACTION_W-1:0] act, logic [15:0] xv,
                                 logic [15:0] yv, logic [31:0] tv);
         position_type p;
         p.status = 0;
         case (act)
            ACT_PUSH: begin
               if (fill >= DEPTH) p.status = 1;
               else begin
                  store[(head + fill) % DEPTH] = {tv, yv, xv};
                  fill++;
               end
            end
            ACT_QUERY: run_query(longint'($signed(tv)));
            ACT_OVERRIDE: begin
               cur_x = longint'($signed(xv));
               cur_y = longint'($signed(yv));
            end
            default: ;
         endcase
         p.x = cur_x[15:0];
         p.y = cur_y[15:0];
         pending.insert(pending.size(), p);
      endfunction

      // Compares one response beat with the oldest expectation.
      task check_response(logic [15:0] px, logic [15:0] py, logic st);
         position_type p;
         if (pending.size() == 0) begin
            report_error($sformatf("unexpected response x=%0d y=%0d", $signed(px),
                                   $signed(py)));
            return;
         end
         p = pending.pop_front();
         if (px !== p.x) report_error($sformatf("pos_x %0d, want %0d", $signed(px), p.x));
         if (py !== p.y) report_error($sformatf("pos_y %0d, want %0d", $signed(py), p.y));
         if (st !== p.status) report_error($sformatf("status %0b, want %0b", st, p.status));
      endtask

      task report_error(string msg);
         errors++;
         $display("ERROR: %s", msg);
      endtask
   endclass

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic csr_index;
   logic [DELAY_W-1:0] csr_write_data;
   int cycles;

   tspi_req_if req_chan();
   tspi_rsp_if rsp_chan();

   position_scoreboard board;

   timestamped_position_interpolator_core DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // Cycle limit as a guard against a hung handshake.
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_CAP) begin
            $display("timestamped_position_interpolator_core test failed");
            $finish;
         end
      end
   end

   // Mostly short gaps, now and then a long one.
   function int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 80);
   endfunction

   // Response side: random stalls, check on each accepted beat.
   bit stall_on;
   initial begin
      rsp_chan.ready = 0;
      stall_on = 1;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready)
            board.check_response(rsp_chan.pos_x, rsp_chan.pos_y, rsp_chan.status);
         @(negedge clock);
         rsp_chan.ready = stall_on ? ($urandom_range(0, 9) < 7) : 1'b1;
         if ($urandom_range(0, 99) == 0) rsp_chan.ready = 0;
      end
   end

   task automatic write_csr(csr_index_type idx, logic [DELAY_W-1:0] value);
      @(negedge clock);
      csr_write_enable = 1;
      csr_index = idx;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 0;
      if (idx == CSR_LERP_ENABLED) board.lerp_on = value[0];
      else board.delay = value;
   endtask

   // Sends one request beat, with a random gap before it when stall_on is set.
   task automatic send_beat(logic [ACTION_W-1:0] act, logic [15:0] xv, logic [15:0] yv,
                            logic [31:0] tv);
      int gap;
      gap = stall_on ? gap_length() : 0;
      repeat (gap) @(negedge clock);
      req_chan.valid = 1;
      req_chan.action = act;
      req_chan.x_value = xv;
      req_chan.y_value = yv;
      req_chan.time_value = tv;
      do @(posedge clock); while (!req_chan.ready);
      board.note_request(act, xv, yv, tv);
      @(negedge clock);
      req_chan.valid = 0;
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   function logic [15:0] any_coord();
      case ($urandom_range(0, 4))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'($signed($urandom_range(0, 600)) - 300);
         default: return 16'($urandom);
      endcase
   endfunction

   // A burst of pushes with non-decreasing times, then queries around them.
   task automatic sample_run(int base);
      int n, t, step;
      n = $urandom_range(1, 5);
      t = base;
      for (int i = 0; i < n; i++) begin
         step = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 60);
         t += step;
         send_beat(ACT_PUSH, any_coord(), any_coord(), t);
      end
      for (int i = 0; i < $urandom_range(1, 4); i++)
         send_beat(ACT_QUERY, 16'($urandom), 16'($urandom),
                   32'(base + board.delay + $urandom_range(0, 80 * n) - 20));
   endtask

   initial begin
      int phase;
      int base;
      board = new();
      reset = 1;
      csr_write_enable = 0;
      csr_index = CSR_LERP_ENABLED;
      csr_write_data = 0;
      req_chan.valid = 0;
      req_chan.action = ACT_PUSH;
      req_chan.x_value = 0;
      req_chan.y_value = 0;
      req_chan.time_value = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed part: snap, override, undefined action, fill to overflow, interpolation corners.
      send_beat(ACT_QUERY, 0, 0, 0);
      send_beat(ACT_OVERRIDE, 16'h7FFF, 16'h8000, 0);
      send_beat(ACT_UNDEF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      for (int i = 0; i < 17; i++)
         send_beat(ACT_PUSH, 16'(i * 300 - 2000), 16'(-i * 77), 32'(i * 10));
      send_beat(ACT_QUERY, 0, 0, 32'h8000_0000);
      drain();
      write_csr(CSR_LERP_ENABLED, 1);
      write_csr(CSR_LERP_DELAY, 16'hFFFF);
      send_beat(ACT_PUSH, 16'h8000, 16'h7FFF, 32'h8000_0000);
      send_beat(ACT_PUSH, 16'h7FFF, 16'h8000, 32'h8000_0000);
      send_beat(ACT_PUSH, 16'd5, 16'd250, 32'h7FFF_FFFF);
      send_beat(ACT_QUERY, 0, 0, 32'h8000_0000);
      send_beat(ACT_QUERY, 0, 0, 32'h7FFF_FFFF);
      send_beat(ACT_QUERY, 0, 0, 32'h7FFF_FFFF);
      drain();

      // Random phases, each under its own register setting.
      stall_on = 1;
      base = 0;
      phase = 0;
      while (phase < 12) begin
         case (phase % 4)
            0: write_csr(CSR_LERP_DELAY, 0);
            1: write_csr(CSR_LERP_DELAY, 16'hFFFF);
            default: write_csr(CSR_LERP_DELAY, 16'($urandom_range(0, 100)));
         endcase
         write_csr(CSR_LERP_ENABLED, (phase % 3) != 0);
         stall_on = (phase % 5) != 4;
         for (int k = 0; k < 8; k++) begin
            if ($urandom_range(0, 9) < 8) sample_run(base);
            else if ($urandom_range(0, 1))
               send_beat(ACT_OVERRIDE, any_coord(), any_coord(), $urandom);
            else
               send_beat(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom), $urandom);
            base += $urandom_range(0, 200);
            if ($urandom_range(0, 15) == 0) base = $urandom;
         end
         drain();
         phase++;
      end

      if (board.errors == 0 && board.pending.size() == 0)
         $display("timestamped_position_interpolator_core test passed");
      else
         $display("timestamped_position_interpolator_core test failed");
      $finish;
   end

endmodule

@@ files.f @@
rtl/tspi_pkg.sv
rtl/tspi_req_if.sv
rtl/tspi_rsp_if.sv
rtl/tspi_ram.sv
rtl/tspi_front.sv
rtl/tspi_back.sv
rtl/timestamped_position_interpolator_core.sv
dv/timestamped_position_interpolator_core_test.sv
